[sv/sitl_pkg.sv]
package sitl_pkg;

   localparam int ID_WIDTH          = 32;
   localparam int DEF_TABLE_DEPTH   = 256;
   localparam int DEF_OFFSET_WIDTH  = 16;
   localparam int DEF_LINES_WIDTH   = 8;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

endpackage

[sv/sitl_table_ram.sv]
module sitl_table_ram import sitl_pkg::*; #(
   parameter int DEPTH      = DEF_TABLE_DEPTH,
   parameter int ADDR_WIDTH = $clog2(DEF_TABLE_DEPTH),
   parameter int DATA_WIDTH = ID_WIDTH + DEF_OFFSET_WIDTH + DEF_LINES_WIDTH
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sitl_ctrl.sv]
module sitl_ctrl import sitl_pkg::*; #(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
   parameter int LINES_WIDTH  = DEF_LINES_WIDTH,
   parameter int IDX_WIDTH    = $clog2(DEF_TABLE_DEPTH),
   parameter int CNT_WIDTH    = $clog2(DEF_TABLE_DEPTH + 1),
   parameter int ENTRY_WIDTH  = ID_WIDTH + DEF_OFFSET_WIDTH + DEF_LINES_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [ID_WIDTH-1:0]     req_id,
   input  logic [OFFSET_WIDTH-1:0] req_offset,
   input  logic [LINES_WIDTH-1:0]  req_lines,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [OFFSET_WIDTH-1:0] rsp_offset,
   output logic [LINES_WIDTH-1:0]  rsp_lines,
   output logic [IDX_WIDTH-1:0]    rsp_position,
   output logic [CNT_WIDTH-1:0]    rsp_count,
   output logic                    rsp_full,
   output logic                    ram_wr_en,
   output logic [IDX_WIDTH-1:0]    ram_wr_addr,
   output logic [ENTRY_WIDTH-1:0]  ram_wr_data,
   output logic [IDX_WIDTH-1:0]    ram_rd_addr,
   input  logic [ENTRY_WIDTH-1:0]  ram_rd_data
);

   localparam logic [CNT_WIDTH-1:0] DEPTH_C = CNT_WIDTH'(TABLE_DEPTH);
   localparam logic [CNT_WIDTH-1:0] ONE_C   = CNT_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SORT_KEY, ST_KEY_WAIT, ST_SHIFT, ST_PLACE, ST_SRCH, ST_CMP, ST_REPLY
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic                     ready_ff, ready_in;
   logic [CNT_WIDTH-1:0]     i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_WIDTH-1:0]     mid_ff, mid_in;
   logic [ENTRY_WIDTH-1:0]   key_ff, key_in;
   logic                     res_found_ff, res_found_in, res_full_ff, res_full_in;
   logic [OFFSET_WIDTH-1:0]  res_off_ff, res_off_in;
   logic [LINES_WIDTH-1:0]   res_lines_ff, res_lines_in;
   logic [IDX_WIDTH-1:0]     res_pos_ff, res_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in, rsp_full_ff, rsp_full_in;
   logic [OFFSET_WIDTH-1:0]  rsp_off_ff, rsp_off_in;
   logic [LINES_WIDTH-1:0]   rsp_lines_ff, rsp_lines_in;
   logic [IDX_WIDTH-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [CNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;

   logic                     advance;
   logic [CNT_WIDTH-1:0]     base, new_count, mid_full;
   logic signed [ID_WIDTH-1:0] key_id, mem_id;

   assign key_id = $signed(key_ff[ENTRY_WIDTH-1 -: ID_WIDTH]);
   assign mem_id = $signed(ram_rd_data[ENTRY_WIDTH-1 -: ID_WIDTH]);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ready_in     = ready_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      res_off_in   = res_off_ff;
      res_lines_in = res_lines_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_lines_in = rsp_lines_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = key_ff;
      ram_rd_addr  = '0;
      advance      = 1'b0;
      base         = ready_ff ? '0 : count_ff;
      new_count    = base;
      mid_full     = lo_ff + ((hi_ff - lo_ff) >> 1);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_found_in = 1'b0;
               res_off_in   = '0;
               res_lines_in = '0;
               res_pos_in   = '0;
               res_full_in  = 1'b0;
               state_in     = ST_REPLY;
               if (req_command == CMD_LOAD) begin
                  ready_in = 1'b0;
                  if (base < DEPTH_C) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = base[IDX_WIDTH-1:0];
                     ram_wr_data = {req_id, req_offset, req_lines};
                     new_count   = base + ONE_C;
                  end else begin
                     res_full_in = 1'b1;
                  end
                  count_in = new_count;
                  if (req_last) begin
                     i_in = ONE_C;
                     if (new_count > ONE_C) begin
                        state_in = ST_SORT_KEY;
                     end else begin
                        ready_in = 1'b1;
                     end
                  end
               end else if (ready_ff && count_ff != '0) begin
                  key_in   = {req_id, {(OFFSET_WIDTH + LINES_WIDTH){1'b0}}};
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SORT_KEY: begin
            ram_rd_addr = i_ff[IDX_WIDTH-1:0];
            state_in    = ST_KEY_WAIT;
         end
         ST_KEY_WAIT: begin
            key_in      = ram_rd_data;
            j_in        = i_ff;
            ram_rd_addr = IDX_WIDTH'(i_ff - ONE_C);
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff[IDX_WIDTH-1:0];
            if (mem_id > key_id) begin
               // Move the larger entry up one place and keep walking down.
               ram_wr_data = ram_rd_data;
               j_in        = j_ff - ONE_C;
               ram_rd_addr = IDX_WIDTH'(j_ff - CNT_WIDTH'(2));
               if (j_ff == ONE_C) begin
                  state_in = ST_PLACE;
               end
            end else begin
               advance = 1'b1;
            end
         end
         ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            advance     = 1'b1;
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_addr = mid_full[IDX_WIDTH-1:0];
               mid_in      = mid_full[IDX_WIDTH-1:0];
               state_in    = ST_CMP;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_CMP: begin
            state_in = ST_SRCH;
            if (key_id > mem_id) begin
               lo_in = CNT_WIDTH'(mid_ff) + ONE_C;
            end else if (key_id < mem_id) begin
               hi_in = CNT_WIDTH'(mid_ff);
            end else begin
               res_found_in = 1'b1;
               res_off_in   = ram_rd_data[LINES_WIDTH +: OFFSET_WIDTH];
               res_lines_in = ram_rd_data[LINES_WIDTH-1:0];
               res_pos_in   = mid_ff;
               state_in     = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
               rsp_off_in   = res_off_ff;
               rsp_lines_in = res_lines_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (i_ff + ONE_C >= count_ff) begin
            ready_in = 1'b1;
            state_in = ST_REPLY;
         end else begin
            i_in     = i_ff + ONE_C;
            state_in = ST_SORT_KEY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      res_off_ff   <= res_off_in;
      res_lines_ff <= res_lines_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_lines_ff <= rsp_lines_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_offset   = rsp_off_ff;
   assign rsp_lines    = rsp_lines_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_full     = rsp_full_ff;

endmodule

[sv/sorted_id_table_lookup_unit.sv]
// Sorted id table. Load words (tuser 0) store one record each, while the table has room,
// in a single-port-write, registered-read table memory and each gets an answer; the word
// with tlast then runs an insertion sort through that memory, shifting each larger record
// up one place until the new record's place is found. A lookup word (tuser 1) runs a
// binary search with one memory read and one compare per step, at most floor(log2(N))+1
// steps for N records. One word is processed at a time; a finished result waits in the
// output register while the next word is taken.
module sorted_id_table_lookup_unit import sitl_pkg::*; #(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
   parameter int LINES_WIDTH  = DEF_LINES_WIDTH,
   parameter int IDX_WIDTH    = $clog2(TABLE_DEPTH),
   parameter int CNT_WIDTH    = $clog2(TABLE_DEPTH + 1),
   parameter int REQ_BITS     = ID_WIDTH + OFFSET_WIDTH + LINES_WIDTH,
   parameter int REQ_DW       = ((REQ_BITS + 7) / 8) * 8,
   parameter int RSP_BITS     = 2 + OFFSET_WIDTH + LINES_WIDTH + IDX_WIDTH + CNT_WIDTH,
   parameter int RSP_DW       = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // record_id, text_offset, line_count
   input  logic [REQ_DW-1:0] req_tdata,
   // command
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // found, found_offset, found_lines, position, record_count, table_full
   output logic [RSP_DW-1:0] rsp_tdata
);

   localparam int ENTRY_WIDTH = REQ_BITS;

   logic                    ram_wr_en;
   logic [IDX_WIDTH-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ENTRY_WIDTH-1:0]  ram_wr_data, ram_rd_data;
   logic                    found, full;
   logic [OFFSET_WIDTH-1:0] found_offset;
   logic [LINES_WIDTH-1:0]  found_lines;
   logic [IDX_WIDTH-1:0]    position;
   logic [CNT_WIDTH-1:0]    record_count;

   sitl_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .LINES_WIDTH (LINES_WIDTH),
      .IDX_WIDTH   (IDX_WIDTH),
      .CNT_WIDTH   (CNT_WIDTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tuser),
      .req_id      (req_tdata[ID_WIDTH-1:0]),
      .req_offset  (req_tdata[ID_WIDTH +: OFFSET_WIDTH]),
      .req_lines   (req_tdata[ID_WIDTH + OFFSET_WIDTH +: LINES_WIDTH]),
      .req_last    (req_tlast),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_found   (found),
      .rsp_offset  (found_offset),
      .rsp_lines   (found_lines),
      .rsp_position(position),
      .rsp_count   (record_count),
      .rsp_full    (full),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   sitl_table_ram #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_WIDTH(IDX_WIDTH),
      .DATA_WIDTH(ENTRY_WIDTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tdata = {{(RSP_DW - RSP_BITS){1'b0}}, full, record_count, position,
                       found_lines, found_offset, found};

endmodule
